// File: src/utg_pkg.sv
// ----------------------------------------------------------------------------
// utg_pkg
// Types and constants of the USB transaction grouper: PID codes, packet
// types, record kinds, the transaction phase and the record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package utg_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 168;

	localparam logic [3:0] PID_SOF    = 4'h5;
	localparam logic [3:0] SPLIT_CODE = 4'h8;
	localparam logic [3:0] PING_CODE  = 4'h4;

	localparam logic [1:0] TYPE_TOKEN     = 2'd1;
	localparam logic [1:0] TYPE_HANDSHAKE = 2'd2;
	localparam logic [1:0] TYPE_DATA      = 2'd3;

	localparam logic [1:0] KIND_SOF   = 2'd0;
	localparam logic [1:0] KIND_TRANS = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_DATA  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] first;
		logic [31:0] count;
		logic        tv;
		logic [31:0] ti;
		logic        dv;
		logic [31:0] di;
		logic        hv;
		logic [31:0] hi;
		logic [3:0]  epid;
		logic        last;
	} rec_t;

endpackage

`default_nettype wire

// File: src/usb_transaction_grouper.sv
// ----------------------------------------------------------------------------
// usb_transaction_grouper
// Numbers captured USB packets, groups SOF runs and builds transaction
// records (token / data / handshake) from a stream of PIDs.
// ----------------------------------------------------------------------------
// Input request: s_tdata[3:0] = PID, s_tuser = 1 for end-of-capture flush.
// Output request: one record; m_tuser = record kind (SOF group, transaction,
// FSM error), m_tdata carries indices, counts and the error PID, m_tlast
// marks the final record caused by one input request.
// Path: a request passes the input register, then the record buffer.
// Throughput: one input request per cycle while the record buffer is free; a
// request yields zero to three records, sent one per cycle while m_tready is
// high. The input register holds the next request while the record buffer
// drains, and the request is processed in the cycle its last predecessor
// record is taken.
// Reset: packet counter, SOF group start, previous PID and transaction
// phase clear; the record buffer empties.
// Stall: while m_tready is low the current record holds; one more request
// is taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_transaction_grouper #(
	parameter int INDEX_BITS = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [utg_pkg::IN_DATA_W-1:0]       s_tdata,  // pid[3:0], zero pad
	input  wire                                 s_tuser,  // mode
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// first_index[31:0], group_count[63:32], token_valid[64],
	// token_index[96:65], data_valid[97], data_index[129:98],
	// handshake_valid[130], handshake_index[162:131], error_pid[166:163], pad
	output logic [utg_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                          m_tuser,  // record_kind
	output logic                                m_tlast
);

	localparam int IW = INDEX_BITS;

	// input register
	logic        valid_s1;
	logic        mode_s1;
	logic [3:0]  pid_s1;

	// grouper state
	utg_pkg::phase_t phase_q, phase_n;
	logic [IW-1:0]   tok_q, tok_n;
	logic [IW-1:0]   dat_q, dat_n;
	logic [3:0]      prev_q, prev_n;
	logic [IW-1:0]   gs_q, gs_n;
	logic [IW-1:0]   cnt_q, cnt_n;

	// record buffer
	utg_pkg::rec_t recs_q [3];
	utg_pkg::rec_t recs_n [3];
	logic [1:0]    left_q;
	logic [1:0]    rd_q;
	logic [1:0]    n_recs;

	logic          proc;
	logic          take;
	logic          free;

	logic          g_emit, t_emit, x_emit, hs_hit, held, hold_dat;
	logic [IW-1:0] span;
	utg_pkg::rec_t g_rec, t_rec, x_rec, out_rec;

	function automatic utg_pkg::rec_t trans_rec(
		input logic tv, input logic [IW-1:0] ti,
		input logic dv, input logic [IW-1:0] di,
		input logic hv, input logic [IW-1:0] hi
	);
		utg_pkg::rec_t r;
		r      = '0;
		r.kind = utg_pkg::KIND_TRANS;
		r.tv   = tv;
		r.ti   = tv ? 32'(ti) : 32'd0;
		r.dv   = dv;
		r.di   = dv ? 32'(di) : 32'd0;
		r.hv   = hv;
		r.hi   = hv ? 32'(hi) : 32'd0;
		return r;
	endfunction

	assign take     = m_tvalid && m_tready;
	assign free     = (left_q == 2'd0) || ((left_q == 2'd1) && m_tready);
	assign proc     = valid_s1 && free;
	assign s_tready = !valid_s1 || proc;

	assign held     = (phase_q != utg_pkg::PH_IDLE);
	assign hold_dat = (phase_q == utg_pkg::PH_DATA);
	assign span     = cnt_q - gs_q;

	always_comb begin
		phase_n = phase_q;
		tok_n   = tok_q;
		dat_n   = dat_q;
		prev_n  = prev_q;
		gs_n    = gs_q;
		cnt_n   = cnt_q;
		g_emit  = 1'b0;
		t_emit  = 1'b0;
		x_emit  = 1'b0;
		hs_hit  = 1'b0;
		x_rec   = '0;

		g_rec       = '0;
		g_rec.kind  = utg_pkg::KIND_SOF;
		g_rec.first = 32'(gs_q);
		g_rec.count = 32'(span);

		if (mode_s1) begin
			g_emit  = (prev_q == utg_pkg::PID_SOF) && (gs_q != cnt_q);
			t_emit  = held;
			phase_n = utg_pkg::PH_IDLE;
			prev_n  = 4'd0;
		end else begin
			if ((prev_q != pid_s1) && (gs_q != cnt_q)) begin
				g_emit = (prev_q == utg_pkg::PID_SOF);
				gs_n   = cnt_q;
			end
			priority if (!held && pid_s1[1:0] == utg_pkg::TYPE_TOKEN
					&& pid_s1 != utg_pkg::PID_SOF) begin
				phase_n = utg_pkg::PH_TOKEN;
				tok_n   = cnt_q;
			end else if (phase_q == utg_pkg::PH_TOKEN
					&& pid_s1[1:0] == utg_pkg::TYPE_DATA) begin
				phase_n = utg_pkg::PH_DATA;
				dat_n   = cnt_q;
			end else if (held && pid_s1[1:0] == utg_pkg::TYPE_HANDSHAKE) begin
				t_emit  = 1'b1;
				hs_hit  = 1'b1;
				phase_n = utg_pkg::PH_IDLE;
			end else if (held && pid_s1[1:0] == utg_pkg::TYPE_TOKEN) begin
				t_emit = 1'b1;
				if (pid_s1 != utg_pkg::PID_SOF) begin
					phase_n = utg_pkg::PH_TOKEN;
					tok_n   = cnt_q;
				end else begin
					phase_n = utg_pkg::PH_IDLE;
				end
			end else if (pid_s1 == utg_pkg::SPLIT_CODE) begin
				t_emit  = held;
				x_emit  = 1'b1;
				x_rec   = trans_rec(1'b1, cnt_q, 1'b0, '0, 1'b0, '0);
				phase_n = utg_pkg::PH_IDLE;
			end else if (pid_s1 == utg_pkg::PING_CODE) begin
				t_emit  = held;
				phase_n = utg_pkg::PH_TOKEN;
				tok_n   = cnt_q;
			end else if (pid_s1 == utg_pkg::PID_SOF) begin
				phase_n = phase_q;
			end else begin
				t_emit      = held;
				x_emit      = 1'b1;
				x_rec.kind  = utg_pkg::KIND_ERROR;
				x_rec.first = 32'(cnt_q);
				x_rec.epid  = pid_s1;
				phase_n     = utg_pkg::PH_IDLE;
			end
			prev_n = pid_s1;
			cnt_n  = cnt_q + IW'(1);
		end

		t_rec = trans_rec(held, tok_q, hold_dat, dat_q, hs_hit, cnt_q);

		recs_n = '{default: '0};
		n_recs = 2'd0;
		if (g_emit) begin
			recs_n[n_recs] = g_rec;
			n_recs         = n_recs + 2'd1;
		end
		if (t_emit) begin
			recs_n[n_recs] = t_rec;
			n_recs         = n_recs + 2'd1;
		end
		if (x_emit) begin
			recs_n[n_recs] = x_rec;
			n_recs         = n_recs + 2'd1;
		end
		if (n_recs != 2'd0) begin
			recs_n[n_recs - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			left_q   <= 2'd0;
			rd_q     <= 2'd0;
			phase_q  <= utg_pkg::PH_IDLE;
			prev_q   <= 4'd0;
			gs_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				left_q  <= n_recs;
				rd_q    <= 2'd0;
				phase_q <= phase_n;
				prev_q  <= prev_n;
				gs_q    <= gs_n;
				cnt_q   <= cnt_n;
			end else if (take) begin
				left_q <= left_q - 2'd1;
				rd_q   <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			pid_s1  <= s_tdata[3:0];
		end
		if (proc) begin
			tok_q  <= tok_n;
			dat_q  <= dat_n;
			recs_q <= recs_n;
		end
	end

	assign out_rec  = recs_q[rd_q];
	assign m_tvalid = (left_q != 2'd0);
	assign m_tuser  = out_rec.kind;
	assign m_tlast  = out_rec.last;
	assign m_tdata  = {1'b0, out_rec.epid, out_rec.hi, out_rec.hv, out_rec.di,
		out_rec.dv, out_rec.ti, out_rec.tv, out_rec.count, out_rec.first};

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rd_q} + {1'b0, left_q}) <= 3'd3)
		else $error("record buffer read past its fill");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (left_q == 2'd1)))
		else $error("tlast not on final buffered record");

	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != utg_pkg::KIND_NONE))
		else $error("record of unused kind sent");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !mode_s1) |=> ((cnt_q - $past(cnt_q)) == INDEX_BITS'(1)))
		else $error("packet counter did not advance by one");

	a_flush_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && mode_s1) |=> ($stable(cnt_q) && phase_q == utg_pkg::PH_IDLE))
		else $error("flush moved counter or left a transaction held");

endmodule

`default_nettype wire
